@@ hw/rtl/crc10_pkg.sv @@
// Constants, types and bit-step function for the CRC10 data PEC unit.
`timescale 1ns / 1ps

package crc10_pkg;

  localparam int unsigned CRC_W     = 10;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned CNT_SHIFT = CRC_W - CNT_W;
  localparam int unsigned BYTE_STEPS  = 8;
  localparam int unsigned CLOSE_STEPS = 6;

  typedef logic [CRC_W-1:0]  crc_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam crc_t CRC_SEED = 10'h010;
  localparam crc_t CRC_POLY = 10'h08F;

  function automatic crc_t crc_step(input crc_t r);
    crc_t s;
    s = {r[CRC_W-2:0], 1'b0};
    if (r[CRC_W-1]) begin
      s = s ^ CRC_POLY;
    end
    return s;
  endfunction

endpackage

@@ hw/rtl/crc10_data_pec_with_counter_unit.sv @@
// Top level of the CRC10 data PEC unit with optional command counter fold.
//
// Usage:
//   Input channel: data_byte, last, with_counter, counter_bits with
//   in_valid/in_stall. A transaction takes place at a rising edge with
//   in_valid high and in_stall low. Bytes of one frame follow in order;
//   last marks the final byte, which may fold counter_bits into remainder
//   bits 9..4 when with_counter is set.
//   Output channel: pec_code with out_valid/out_stall, one transaction per
//   frame.
//   The final byte is first taken into the input register; the code of the
//   frame is then held in the result register and shown with out_valid.
//   Throughput: one byte per cycle while in_stall is low; the eight byte
//   bit steps and the six closing steps are unrolled XOR logic between the
//   input register and the remainder and result registers.
//   Stall: the result register holds while out_stall is high; a following
//   non-final byte still advances, and in_stall rises only when a final
//   byte waits behind a stalled result.
//   Reset: rst (synchronous) empties both registers and loads the seed 16
//   into the remainder.
`timescale 1ns / 1ps

module crc10_data_pec_with_counter_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  crc10_pkg::byte_t    data_byte,
  input  logic                last,
  input  logic                with_counter,
  input  crc10_pkg::cnt_t     counter_bits,
  output logic                out_valid,
  input  logic                out_stall,
  output crc10_pkg::crc_t     pec_code
);

  import crc10_pkg::*;

  logic  s1_valid;
  byte_t s1_byte;
  logic  s1_last;
  logic  s1_withc;
  cnt_t  s1_cnt;
  logic  s1_adv;

  crc_t  remainder;
  crc_t  remainder_next;
  crc_t  r_byte;
  crc_t  r_close;
  crc_t  r_fold;

  assign s1_adv   = !s1_last || !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_adv;

  always_comb begin
    r_byte = remainder ^ {s1_byte, 2'b00};
    for (int i = 0; i < BYTE_STEPS; i++) begin
      r_byte = crc_step(r_byte);
    end
    r_fold = r_byte;
    if (s1_withc) begin
      r_fold = r_byte ^ {s1_cnt, {CNT_SHIFT{1'b0}}};
    end
    r_close = r_fold;
    for (int i = 0; i < CLOSE_STEPS; i++) begin
      r_close = crc_step(r_close);
    end
    remainder_next = remainder;
    if (s1_valid && s1_adv) begin
      remainder_next = s1_last ? CRC_SEED : r_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte  <= data_byte;
      s1_last  <= last;
      s1_withc <= with_counter;
      s1_cnt   <= counter_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= CRC_SEED;
    end else begin
      remainder <= remainder_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_last && s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_last && s1_adv) begin
      pec_code <= r_close;
    end
  end

  a_reset_seed: assert property (@(posedge clk)
    rst |=> remainder == CRC_SEED)
    else $error("remainder not seeded after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_last && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_frame_reseed: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_last && s1_adv) |=> remainder == CRC_SEED)
    else $error("remainder not reseeded at frame end");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_last))
    else $error("result without a final byte");

endmodule
